// ===== rtl/tlb_page_table_translator_macros.svh =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator_macros
// assertion shorthands shared by the translator rtl
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// shared constants and types for the tlb / page table translator
// ----------------------------------------------------------------------------
package tpt_pkg;

  // default sizes
  localparam int TPT_TLB_ENTRIES = 16;
  localparam int TPT_PAGE_COUNT  = 256;
  localparam int TPT_FRAME_COUNT = 256;
  localparam int TPT_OFFSET_BITS = 8;

  // fixed field widths
  localparam int TPT_ADDR_W = 16;
  localparam int TPT_CNT_W  = 32;

  // shift used by the reciprocal page reduction
  localparam int TPT_RECIP_SHIFT = 24;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_TABLE
  } state_t;

  // result flags of one transaction
  typedef struct packed {
    logic valid;
    logic hit;
    logic fault;
    logic exhausted;
  } res_flags_t;

endpackage

// ===== rtl/tpt_ram.sv =====
// ----------------------------------------------------------------------------
// tpt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tpt_tlb
// fully associative tlb with fifo replacement, lowest matching entry wins
// ----------------------------------------------------------------------------
module tpt_tlb #(
  parameter int ENTRIES = 16,
  parameter int PAGE_W  = 8,
  parameter int FRAME_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PAGE_W-1:0]  lookup_page,
  output logic               hit,
  output logic [FRAME_W-1:0] hit_frame,
  input  logic               load_en,
  input  logic [PAGE_W-1:0]  load_page,
  input  logic [FRAME_W-1:0] load_frame
);

  import tpt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [ENTRIES-1:0] valid_r;
  logic [PAGE_W-1:0]  page_r  [ENTRIES];
  logic [FRAME_W-1:0] frame_r [ENTRIES];
  logic [IDX_W-1:0]   slot_r;
  logic [IDX_W-1:0]   slot_nxt;
  logic               started_r;
  logic [IDX_W-1:0]   hit_idx;

  // parallel compare, priority to the lowest entry
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (page_r[i] == lookup_page)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_frame = frame_r[hit_idx];

  // fifo slot: first load goes to slot zero, later ones advance with wrap
  always_comb begin
    if (!started_r) begin
      slot_nxt = '0;
    end else if (slot_r == IDX_W'(ENTRIES - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + IDX_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      slot_r    <= '0;
      started_r <= 1'b0;
    end else if (load_en) begin
      valid_r[slot_nxt] <= 1'b1;
      slot_r            <= slot_nxt;
      started_r         <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (load_en) begin
      page_r[slot_nxt]  <= load_page;
      frame_r[slot_nxt] <= load_frame;
    end
  end

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// A tlb hit is resolved in ST_LOOKUP, a tlb miss in ST_TABLE after the page table
// ram read; out_valid is registered from the result of either state.
// A new start is taken only in ST_IDLE, after the last result; start is taken
// again in the cycle the result strobe is shown. The receiver cannot stall.
// Reset: synchronous, active low; afterwards busy stays high in ST_CLEAR while
// the page table is cleared one entry a cycle.
`include "tlb_page_table_translator_macros.svh"

// ----------------------------------------------------------------------------
// tlb_page_table_translator
// logical to physical address translation through a tlb and a page table
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tpt_pkg::TPT_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tpt_pkg::TPT_PAGE_COUNT,
  parameter int FRAME_COUNT = tpt_pkg::TPT_FRAME_COUNT,
  parameter int OFFSET_BITS = tpt_pkg::TPT_OFFSET_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tpt_pkg::TPT_ADDR_W-1:0] in_logical_addr,
  output logic                         out_valid,
  output logic [tpt_pkg::TPT_ADDR_W-1:0] out_physical_addr,
  output logic                         out_tlb_hit,
  output logic                         out_page_fault,
  output logic                         out_frames_exhausted,
  output logic [tpt_pkg::TPT_CNT_W-1:0]  out_translated_count,
  output logic [tpt_pkg::TPT_CNT_W-1:0]  out_hit_count,
  output logic [tpt_pkg::TPT_CNT_W-1:0]  out_fault_count
);

  import tpt_pkg::*;

  localparam int PRAW_W    = (TPT_ADDR_W > OFFSET_BITS) ? TPT_ADDR_W - OFFSET_BITS : 1;
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int FREE_W    = $clog2(FRAME_COUNT + 1);
  localparam int ENTRY_W   = FRAME_W + 1;
  localparam int RECIP_MUL = ((2 ** TPT_RECIP_SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam int RECIP_W   = $clog2(RECIP_MUL + 1);
  localparam int PROD_W    = PRAW_W + RECIP_W;

  state_t              state_r;
  state_t              state_nxt;
  logic [TPT_ADDR_W-1:0] addr_r;
  logic [PRAW_W-1:0]   quot_r;
  logic [PAGE_W-1:0]   page_r;
  logic [PAGE_W-1:0]   clr_r;
  logic [FREE_W-1:0]   free_r;
  logic                accept;

  logic [PRAW_W-1:0]   in_page_raw;
  logic [PROD_W-1:0]   recip_prod;
  logic [PRAW_W-1:0]   quot_nxt;
  logic [PRAW_W-1:0]   page_raw;
  logic [PRAW_W-1:0]   quot_back;
  logic [PAGE_W-1:0]   page_cur;

  logic                ram_we;
  logic [PAGE_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ent_valid;
  logic [FRAME_W-1:0]  ent_frame;
  logic                free_avail;

  logic                tlb_hit;
  logic [FRAME_W-1:0]  tlb_frame;
  logic                tlb_load;

  res_flags_t          res;
  logic [FRAME_W-1:0]  res_frame;
  logic                res_valid_r;
  logic [TPT_ADDR_W-1:0] phys_r;
  logic                hit_r;
  logic                fault_r;
  logic                exh_r;
  logic [TPT_CNT_W-1:0] cnt_trans_r;
  logic [TPT_CNT_W-1:0] cnt_hit_r;
  logic [TPT_CNT_W-1:0] cnt_fault_r;

  assign accept = start && !busy;

  // page number reduced modulo the table size: reciprocal quotient at accept
  assign in_page_raw = PRAW_W'(in_logical_addr >> OFFSET_BITS);
  assign recip_prod  = PROD_W'(in_page_raw) * PROD_W'(RECIP_MUL);
  assign quot_nxt    = PRAW_W'(recip_prod >> TPT_RECIP_SHIFT);

  // remainder from the registered quotient
  assign page_raw  = PRAW_W'(addr_r >> OFFSET_BITS);
  assign quot_back = quot_r * PRAW_W'(PAGE_COUNT);
  assign page_cur  = PAGE_W'(page_raw - quot_back);

  // page table entry fields
  assign ent_valid  = ram_rdata[FRAME_W];
  assign ent_frame  = ram_rdata[FRAME_W-1:0];
  assign free_avail = free_r < FREE_W'(FRAME_COUNT);

  // page table storage
  tpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (page_cur),
    .rdata (ram_rdata)
  );

  // tlb
  tpt_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PAGE_W  (PAGE_W),
    .FRAME_W (FRAME_W)
  ) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_cur),
    .hit         (tlb_hit),
    .hit_frame   (tlb_frame),
    .load_en     (tlb_load),
    .load_page   (page_r),
    .load_frame  (res_frame)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == PAGE_W'(PAGE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = tlb_hit ? ST_IDLE : ST_TABLE;
      end
      ST_TABLE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state outputs: ram access, tlb load and result flags
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = page_r;
    ram_wdata = '0;
    tlb_load  = 1'b0;
    res       = '0;
    res_frame = ent_frame;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_LOOKUP: begin
        res_frame = tlb_frame;
        if (tlb_hit) begin
          res.valid = 1'b1;
          res.hit   = 1'b1;
        end
      end
      ST_TABLE: begin
        res.valid = 1'b1;
        if (ent_valid) begin
          tlb_load = 1'b1;
        end else begin
          res.fault = 1'b1;
          res_frame = FRAME_W'(free_r);
          if (free_avail) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, res_frame};
            tlb_load  = 1'b1;
          end else begin
            res.exhausted = 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // control registers and running counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      free_r      <= '0;
      res_valid_r <= 1'b0;
      cnt_trans_r <= '0;
      cnt_hit_r   <= '0;
      cnt_fault_r <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res.valid;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + PAGE_W'(1);
      end
      if (res.fault && !res.exhausted) begin
        free_r <= free_r + FREE_W'(1);
      end
      if (res.valid) begin
        cnt_trans_r <= cnt_trans_r + TPT_CNT_W'(1);
      end
      if (res.hit) begin
        cnt_hit_r <= cnt_hit_r + TPT_CNT_W'(1);
      end
      if (res.fault) begin
        cnt_fault_r <= cnt_fault_r + TPT_CNT_W'(1);
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_logical_addr;
      quot_r <= quot_nxt;
    end
    if (state_r == ST_LOOKUP) begin
      page_r <= page_cur;
    end
    if (res.valid) begin
      phys_r  <= res.exhausted ? '0
                 : TPT_ADDR_W'({res_frame, addr_r[OFFSET_BITS-1:0]});
      hit_r   <= res.hit;
      fault_r <= res.fault;
      exh_r   <= res.exhausted;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_physical_addr    = phys_r;
  assign out_tlb_hit          = hit_r;
  assign out_page_fault       = fault_r;
  assign out_frames_exhausted = exh_r;
  assign out_translated_count = cnt_trans_r;
  assign out_hit_count        = cnt_hit_r;
  assign out_fault_count      = cnt_fault_r;

  // checks
  `TPT_ASSERT_NOW(a_exh_is_fault, out_valid && out_frames_exhausted, out_page_fault, "exhausted without fault")
  `TPT_ASSERT_NOW(a_hit_no_fault, out_valid, !(out_tlb_hit && out_page_fault), "hit and fault together")
  `TPT_ASSERT_NOW(a_exh_zero_addr, out_valid && out_frames_exhausted, out_physical_addr == '0, "address not zero when out of frames")
  `TPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accepted transaction not in progress")
  `TPT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")

endmodule

// ===== sim/tlb_page_table_translator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Drives logical addresses into the translator through the start/busy
// handshake. A local model of the tlb, the page table and the free frame
// pointer predicts every result. Each strobed result is checked field by
// field against the oldest prediction. Directed cases cover the extremes,
// fifo wrap and table refills. Random phases cover tlb locality, tlb
// thrashing, wide random pages, a full table sweep and traffic after all
// frames are handed out.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

  import tpt_pkg::*;

  localparam int PAGE_W      = $clog2(TPT_PAGE_COUNT);
  localparam int FRAME_W     = $clog2(TPT_FRAME_COUNT);
  localparam int STALL_LIMIT = 2000;

  // one predicted translation
  typedef struct {
    logic [TPT_ADDR_W-1:0] phys;
    logic                  hit;
    logic                  fault;
    logic                  exhausted;
    logic [TPT_CNT_W-1:0]  n_xlated;
    logic [TPT_CNT_W-1:0]  n_hits;
    logic [TPT_CNT_W-1:0]  n_faults;
  } xlate_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [TPT_ADDR_W-1:0] in_logical_addr = '0;
  logic                  busy;
  logic                  out_valid;
  logic [TPT_ADDR_W-1:0] out_physical_addr;
  logic                  out_tlb_hit;
  logic                  out_page_fault;
  logic                  out_frames_exhausted;
  logic [TPT_CNT_W-1:0]  out_translated_count;
  logic [TPT_CNT_W-1:0]  out_hit_count;
  logic [TPT_CNT_W-1:0]  out_fault_count;

  // model state of the translator
  logic                  tlb_ok [TPT_TLB_ENTRIES];
  logic [PAGE_W-1:0]     tlb_pg [TPT_TLB_ENTRIES];
  logic [FRAME_W-1:0]    tlb_fr [TPT_TLB_ENTRIES];
  logic                  tbl_ok [TPT_PAGE_COUNT];
  logic [FRAME_W-1:0]    tbl_fr [TPT_PAGE_COUNT];
  int unsigned           fifo_ptr;
  logic                  fifo_used;
  logic [FRAME_W:0]      free_frame;
  logic [TPT_CNT_W-1:0]  cnt_xlated;
  logic [TPT_CNT_W-1:0]  cnt_hits;
  logic [TPT_CNT_W-1:0]  cnt_faults;

  xlate_t pending_xlate[$];
  int     mismatches = 0;
  int     stall_cycles = 0;
  bit     driving = 1'b0;
  bit     no_idle = 1'b0;

  tlb_page_table_translator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_logical_addr      (in_logical_addr),
    .out_valid            (out_valid),
    .out_physical_addr    (out_physical_addr),
    .out_tlb_hit          (out_tlb_hit),
    .out_page_fault       (out_page_fault),
    .out_frames_exhausted (out_frames_exhausted),
    .out_translated_count (out_translated_count),
    .out_hit_count        (out_hit_count),
    .out_fault_count      (out_fault_count)
  );

  always #6 clk = ~clk;

  // clear the model to its post-reset contents
  task automatic clear_model();
    for (int i = 0; i < TPT_TLB_ENTRIES; i++) begin
      tlb_ok[i] = 1'b0;
      tlb_pg[i] = '0;
      tlb_fr[i] = '0;
    end
    for (int i = 0; i < TPT_PAGE_COUNT; i++) begin
      tbl_ok[i] = 1'b0;
      tbl_fr[i] = '0;
    end
    fifo_ptr   = 0;
    fifo_used  = 1'b0;
    free_frame = '0;
    cnt_xlated = '0;
    cnt_hits   = '0;
    cnt_faults = '0;
  endtask

  // fifo replacement: first load lands in slot 0, later ones advance
  task automatic fill_tlb_slot(input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr);
    if (!fifo_used) begin
      fifo_used = 1'b1;
      fifo_ptr  = 0;
    end else begin
      fifo_ptr = (fifo_ptr + 1) % TPT_TLB_ENTRIES;
    end
    tlb_ok[fifo_ptr] = 1'b1;
    tlb_pg[fifo_ptr] = pg;
    tlb_fr[fifo_ptr] = fr;
  endtask

  // translate one address and update the model state
  task automatic predict_translation(input logic [TPT_ADDR_W-1:0] addr, output xlate_t res);
    int unsigned        offs;
    int unsigned        wide;
    logic [PAGE_W-1:0]  pg;
    logic [FRAME_W-1:0] fr;
    logic               hit;
    logic               fault;
    logic               exh;
    offs  = addr & ((1 << TPT_OFFSET_BITS) - 1);
    pg    = PAGE_W'((int'(addr) >> TPT_OFFSET_BITS) % TPT_PAGE_COUNT);
    fr    = '0;
    hit   = 1'b0;
    fault = 1'b0;
    exh   = 1'b0;
    cnt_xlated++;
    // lowest matching tlb entry wins
    for (int i = 0; i < TPT_TLB_ENTRIES; i++) begin
      if (!hit && tlb_ok[i] && tlb_pg[i] == pg) begin
        hit = 1'b1;
        fr  = tlb_fr[i];
      end
    end
    if (hit) begin
      cnt_hits++;
    end else if (tbl_ok[pg]) begin
      fr = tbl_fr[pg];
      fill_tlb_slot(pg, fr);
    end else begin
      fault = 1'b1;
      cnt_faults++;
      if (free_frame < TPT_FRAME_COUNT) begin
        fr         = free_frame[FRAME_W-1:0];
        tbl_ok[pg] = 1'b1;
        tbl_fr[pg] = fr;
        fill_tlb_slot(pg, fr);
        free_frame++;
      end else begin
        exh = 1'b1;
      end
    end
    wide          = (int'(fr) << TPT_OFFSET_BITS) + offs;
    res.phys      = exh ? '0 : wide[TPT_ADDR_W-1:0];
    res.hit       = hit;
    res.fault     = fault;
    res.exhausted = exh;
    res.n_xlated  = cnt_xlated;
    res.n_hits    = cnt_hits;
    res.n_faults  = cnt_faults;
  endtask

  // send one address; returns at the edge that accepted it
  task automatic send_addr(input logic [TPT_ADDR_W-1:0] addr);
    int     gap;
    xlate_t exp_res;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      if (driving) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_logical_addr <= addr;
    driving = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_translation(addr, exp_res);
    pending_xlate.push_back(exp_res);
  endtask

  // lower start at the accepting edge of the last transaction
  task automatic stop_driving();
    if (driving) start <= 1'b0;
    driving = 1'b0;
  endtask

  // switch between idle-free bursts and random gaps
  task automatic pick_idle_mode(input int idx);
    if (idx % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // extremes, first tlb load, fifo wrap and table refills
  task automatic test_directed();
    send_addr(16'h0000);
    send_addr(16'h00ff);
    send_addr(16'hffff);
    send_addr(16'hff00);
    send_addr(16'h5aa5);
    send_addr(16'ha55a);
    // fill the remaining slots, then wrap over slot 0
    for (int p = 1; p <= 13; p++) begin
      send_addr({p[7:0], 8'($urandom)});
    end
    // evicted pages come back from the page table, then page 13 hits in slot 0
    send_addr(16'h0012);
    send_addr(16'hff34);
    send_addr(16'h5a00);
    send_addr(16'h0d80);
  endtask

  // small working set, mostly tlb hits
  task automatic test_tlb_locality();
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < 200; i++) begin
      pick_idle_mode(i);
      send_addr({base + 8'($urandom_range(0, 7)), 8'($urandom)});
    end
  endtask

  // working set larger than the tlb, forcing fifo eviction and table hits
  task automatic test_tlb_thrash();
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < 200; i++) begin
      pick_idle_mode(i);
      send_addr({base + 8'($urandom_range(0, 23)), 8'($urandom)});
    end
  endtask

  // fully random addresses, mostly page faults early on
  task automatic test_wide_random();
    for (int i = 0; i < 300; i++) begin
      pick_idle_mode(i);
      send_addr(16'($urandom));
    end
  endtask

  // every page once in shuffled order, handing out all frames
  task automatic test_table_sweep();
    logic [7:0] order [TPT_PAGE_COUNT];
    logic [7:0] tmp;
    int         j;
    for (int i = 0; i < TPT_PAGE_COUNT; i++) order[i] = 8'(i);
    for (int i = TPT_PAGE_COUNT - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < TPT_PAGE_COUNT; i++) begin
      pick_idle_mode(i);
      send_addr({order[i], 8'($urandom)});
    end
  endtask

  // all frames used: only tlb hits and table refills remain
  task automatic test_after_fill();
    for (int i = 0; i < 120; i++) begin
      pick_idle_mode(i);
      if ($urandom_range(0, 1) == 0) send_addr(16'($urandom));
      else send_addr({8'($urandom_range(0, 5)), 8'($urandom)});
    end
  endtask

  // compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    xlate_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_xlate.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_physical_addr), 32'h0);
      end else begin
        want = pending_xlate.pop_front();
        if (out_physical_addr !== want.phys)
          report_mismatch("physical_addr", 32'(out_physical_addr), 32'(want.phys));
        if (out_tlb_hit !== want.hit)
          report_mismatch("tlb_hit", 32'(out_tlb_hit), 32'(want.hit));
        if (out_page_fault !== want.fault)
          report_mismatch("page_fault", 32'(out_page_fault), 32'(want.fault));
        if (out_frames_exhausted !== want.exhausted)
          report_mismatch("frames_exhausted", 32'(out_frames_exhausted),
                          32'(want.exhausted));
        if (out_translated_count !== want.n_xlated)
          report_mismatch("translated_count", out_translated_count, want.n_xlated);
        if (out_hit_count !== want.n_hits)
          report_mismatch("hit_count", out_hit_count, want.n_hits);
        if (out_fault_count !== want.n_faults)
          report_mismatch("fault_count", out_fault_count, want.n_faults);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("tlb_page_table_translator_tb: FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    clear_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_tlb_locality();
    test_tlb_thrash();
    test_wide_random();
    test_table_sweep();
    test_after_fill();
    stop_driving();
    while (pending_xlate.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_xlate.size() != 0)
      report_mismatch("missing results", 32'(pending_xlate.size()), 32'h0);
    if (mismatches == 0) begin
      $display("tlb_page_table_translator_tb: PASS");
    end else begin
      $display("tlb_page_table_translator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tpt_pkg.sv
rtl/tpt_ram.sv
rtl/tpt_tlb.sv
rtl/tlb_page_table_translator.sv
sim/tlb_page_table_translator_tb.sv
